[hw/rtl/gsvt_pkg.sv]
// Shared types and constants for the global symbol value table.
// Holds the request kind codes, class codes and the control record that
// travels from cell to cell. Depends on nothing.
package gsvt_pkg;

  localparam int KEY_BITS       = 16;
  localparam int SLOT_OUT_BITS  = 5;
  localparam int VALUE_OUT_BITS = 32;

  // Request kinds as they arrive on the input channel.
  typedef enum logic [1:0] {
    KIND_STORE_GLOBAL = 2'd0,
    KIND_STORE_CONST  = 2'd1,
    KIND_FETCH_GLOBAL = 2'd2,
    KIND_FETCH_CONST  = 2'd3
  } kind_t;

  // Entry class codes.
  localparam logic CLASS_GLOBAL = 1'b0;
  localparam logic CLASS_CONST  = 1'b1;

  // Control part of a request in flight along the chain.
  typedef struct packed {
    logic                valid;
    logic                is_store;
    logic                cls;
    logic                hit;     // a matching entry was found upstream
    logic                placed;  // a new entry was appended upstream
    logic [KEY_BITS-1:0] key;
  } gsvt_ctl_t;

endpackage

[hw/rtl/gsvt_cell.sv]
// One table entry of the global symbol value table plus its request stage.
// Compares the passing request against its entry, updates the entry and
// hands the request to the next cell. Depends on gsvt_pkg.
module gsvt_cell
  import gsvt_pkg::*;
#(
  parameter int CELL_INDEX = 0,
  parameter int SLOT_BITS  = 5,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  gsvt_ctl_t             ctl_in,
  input  logic [SLOT_BITS-1:0]  slot_in,
  input  logic [VALUE_BITS-1:0] value_in,
  output gsvt_ctl_t             ctl_out,
  output logic [SLOT_BITS-1:0]  slot_out,
  output logic [VALUE_BITS-1:0] value_out
);

  // Entry storage. The used flag marks the filled prefix of the table.
  logic                  used;
  logic                  entry_class;
  logic [KEY_BITS-1:0]   entry_key;
  logic [VALUE_BITS-1:0] entry_value;

  // Request stage register.
  gsvt_ctl_t             tok_ctl;
  logic [SLOT_BITS-1:0]  tok_slot;
  logic [VALUE_BITS-1:0] tok_value;

  logic                  found;
  logic                  match;
  logic                  append;
  gsvt_ctl_t             ctl_next;
  logic [SLOT_BITS-1:0]  slot_next;
  logic [VALUE_BITS-1:0] value_next;

  // Match only if no earlier cell has claimed the request, so the lowest
  // matching entry wins. The first unused cell takes an unclaimed store.
  always_comb begin
    found      = ctl_in.hit | ctl_in.placed;
    match      = ctl_in.valid & ~found & used & (entry_class == ctl_in.cls) &
                 (entry_key == ctl_in.key);
    append     = ctl_in.valid & ~found & ~used & ctl_in.is_store;
    ctl_next   = ctl_in;
    slot_next  = slot_in;
    value_next = value_in;
    if (match) begin
      ctl_next.hit = 1'b1;
      slot_next    = SLOT_BITS'(CELL_INDEX);
      if (!ctl_in.is_store) begin
        value_next = entry_value;
      end
    end
    if (append) begin
      ctl_next.placed = 1'b1;
      slot_next       = SLOT_BITS'(CELL_INDEX);
    end
  end

  // Control state: stage control record and entry fill flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_ctl <= '0;
      used    <= 1'b0;
    end else if (advance) begin
      tok_ctl <= ctl_next;
      if (append) begin
        used <= 1'b1;
      end
    end
  end

  // Payload and entry contents.
  always_ff @(posedge clk) begin
    if (advance) begin
      tok_slot  <= slot_next;
      tok_value <= value_next;
      if (append) begin
        entry_class <= ctl_in.cls;
        entry_key   <= ctl_in.key;
      end
      if (append || (match && ctl_in.is_store)) begin
        entry_value <= value_in;
      end
    end
  end

  assign ctl_out   = tok_ctl;
  assign slot_out  = tok_slot;
  assign value_out = tok_value;

endmodule

[hw/rtl/global_symbol_value_table.sv]
// Global symbol value table: a chain of TABLE_DEPTH entry cells.
// A request walks the chain one cell per clock while the output is not
// stalled, passing the stage register of each cell. Throughput: one request
// per cycle while the output is not stalled. Reset clears all requests in
// flight and empties the table; entry contents hold no defined value until
// written. Depends on gsvt_pkg and gsvt_cell.
module global_symbol_value_table
  import gsvt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                kind,
  input  logic [KEY_BITS-1:0]       symbol_key,
  input  logic [31:0]               store_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      hit,
  output logic [VALUE_OUT_BITS-1:0] fetched_value,
  output logic                      table_full,
  output logic [SLOT_OUT_BITS-1:0]  slot
);

  localparam int SLOT_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  gsvt_ctl_t             ctl_chain   [0:TABLE_DEPTH];
  logic [SLOT_BITS-1:0]  slot_chain  [0:TABLE_DEPTH];
  logic [VALUE_BITS-1:0] value_chain [0:TABLE_DEPTH];
  logic                  advance;
  logic                  req_store;
  logic                  req_cls;
  gsvt_ctl_t             head_ctl;
  gsvt_ctl_t             last_ctl;

  // The whole chain moves unless a finished result is held at the output.
  assign advance  = ~out_valid | ~out_stall;
  assign in_stall = ~advance;

  // Decode the request kind.
  always_comb begin
    unique case (kind_t'(kind))
      KIND_STORE_GLOBAL: begin req_store = 1'b1; req_cls = CLASS_GLOBAL; end
      KIND_STORE_CONST:  begin req_store = 1'b1; req_cls = CLASS_CONST;  end
      KIND_FETCH_GLOBAL: begin req_store = 1'b0; req_cls = CLASS_GLOBAL; end
      KIND_FETCH_CONST:  begin req_store = 1'b0; req_cls = CLASS_CONST;  end
      default:           begin req_store = 1'b0; req_cls = CLASS_GLOBAL; end
    endcase
  end

  // Head of the chain: the incoming request, not yet claimed by any cell.
  always_comb begin
    head_ctl          = '0;
    head_ctl.valid    = in_valid;
    head_ctl.is_store = req_store;
    head_ctl.cls      = req_cls;
    head_ctl.key      = symbol_key;
  end

  assign ctl_chain[0]   = head_ctl;
  assign slot_chain[0]  = '0;
  assign value_chain[0] = VALUE_BITS'(store_value);

  // One cell per table entry.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    gsvt_cell #(
      .CELL_INDEX(i),
      .SLOT_BITS (SLOT_BITS),
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .ctl_in   (ctl_chain[i]),
      .slot_in  (slot_chain[i]),
      .value_in (value_chain[i]),
      .ctl_out  (ctl_chain[i+1]),
      .slot_out (slot_chain[i+1]),
      .value_out(value_chain[i+1])
    );
  end

  // The last cell's stage register is the output register.
  assign last_ctl   = ctl_chain[TABLE_DEPTH];
  assign out_valid  = last_ctl.valid;
  assign hit        = last_ctl.hit;
  assign table_full = last_ctl.is_store & ~last_ctl.hit & ~last_ctl.placed;
  assign slot       = SLOT_OUT_BITS'(slot_chain[TABLE_DEPTH]);

  // Only a fetch that hit returns a value; everything else returns nil.
  always_comb begin
    if (!last_ctl.is_store && last_ctl.hit) begin
      fetched_value = VALUE_OUT_BITS'(value_chain[TABLE_DEPTH]);
    end else begin
      fetched_value = '0;
    end
  end

endmodule

[dv/tb_top.sv]
// Self-checking bench for the global symbol value table (store and fetch by class and key).
// Uses the request kind and class codes from gsvt_pkg and drives global_symbol_value_table.
// A scoreboard class predicts every result in request order.
module tb_top
  import gsvt_pkg::*;
();

  localparam int DEPTH      = 32;
  localparam int KEY_POOL   = 20;
  localparam int RAND_ITEMS = 1780;

  // Expected contents of one result.
  typedef struct {
    logic                      hit;
    logic [VALUE_OUT_BITS-1:0] value;
    logic                      full;
    logic [SLOT_OUT_BITS-1:0]  slot;
  } table_result_t;

  // Tracks the table contents and checks the results against them.
  class symbol_table_scoreboard;
    logic                cls_of [DEPTH];
    logic [KEY_BITS-1:0] key_of [DEPTH];
    logic [31:0]         value_of [DEPTH];
    int unsigned         fill;
    table_result_t       expected_q[$];
    int unsigned         mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    // Lowest filled entry with the same class and key, or -1.
    function int find_entry(logic cls, logic [KEY_BITS-1:0] key);
      for (int i = 0; i < fill; i++) begin
        if (cls_of[i] == cls && key_of[i] == key) return i;
      end
      return -1;
    endfunction

    // Updates the table for an accepted request and queues its result.
    function void note_request(kind_t k, logic [KEY_BITS-1:0] key, logic [31:0] value);
      logic          cls;
      logic          is_store;
      int            idx;
      int            target;
      table_result_t r;
      cls = (k == KIND_STORE_CONST || k == KIND_FETCH_CONST) ? CLASS_CONST : CLASS_GLOBAL;
      is_store = (k == KIND_STORE_GLOBAL || k == KIND_STORE_CONST);
      idx = find_entry(cls, key);
      r.hit = 1'b0;
      r.value = '0;
      r.full = 1'b0;
      r.slot = '0;
      if (is_store) begin
        target = -1;
        if (idx >= 0) begin
          r.hit = 1'b1;
          target = idx;
        end else if (fill >= DEPTH) begin
          r.full = 1'b1;
        end else begin
          target = fill;
          fill++;
        end
        if (target >= 0) begin
          cls_of[target] = cls;
          key_of[target] = key;
          value_of[target] = value;
          r.slot = target[SLOT_OUT_BITS-1:0];
        end
      end else if (idx >= 0) begin
        r.hit = 1'b1;
        r.value = value_of[idx];
        r.slot = idx[SLOT_OUT_BITS-1:0];
      end
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    // Compares one accepted result with the oldest prediction.
    task check_result(logic got_hit, logic [VALUE_OUT_BITS-1:0] got_value, logic got_full,
                      logic [SLOT_OUT_BITS-1:0] got_slot);
      table_result_t r;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request pending");
        return;
      end
      r = expected_q.pop_front();
      if (got_hit !== r.hit)
        report_mismatch($sformatf("hit got %b want %b", got_hit, r.hit));
      if (got_value !== r.value)
        report_mismatch($sformatf("fetched_value got %h want %h", got_value, r.value));
      if (got_full !== r.full)
        report_mismatch($sformatf("table_full got %b want %b", got_full, r.full));
      if (got_slot !== r.slot)
        report_mismatch($sformatf("slot got %0d want %0d", got_slot, r.slot));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                kind = KIND_FETCH_GLOBAL;
  logic [KEY_BITS-1:0]       symbol_key = '0;
  logic [31:0]               store_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      hit;
  logic [VALUE_OUT_BITS-1:0] fetched_value;
  logic                      table_full;
  logic [SLOT_OUT_BITS-1:0]  slot;

  logic                      idle_on = 1'b1;
  logic [KEY_BITS-1:0]       key_pool [KEY_POOL];

  symbol_table_scoreboard sb = new();

  global_symbol_value_table #(
    .TABLE_DEPTH(DEPTH),
    .VALUE_BITS (32)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .symbol_key   (symbol_key),
    .store_value  (store_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .fetched_value(fetched_value),
    .table_full   (table_full),
    .slot         (slot)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  // Random backpressure on the result side.
  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 25);
  end

  // Both handshakes are observed at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_request(kind_t'(kind), symbol_key, store_value);
      if (out_valid && !out_stall)
        sb.check_result(hit, fetched_value, table_full, slot);
    end
  end

  // Presents one request, with an optional idle gap first, and waits for it to be taken.
  task automatic send_request(kind_t k, logic [KEY_BITS-1:0] key, logic [31:0] value);
    while (idle_on && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    symbol_key <= key;
    store_value <= value;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    kind_t               k;
    logic [KEY_BITS-1:0] key;

    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = KEY_BITS'($urandom_range(16'hFFFF));

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty-table miss, both classes on one key, key and value extremes.
    send_request(KIND_FETCH_GLOBAL, 16'h0000, 32'h1234_5678);
    send_request(KIND_STORE_GLOBAL, 16'h0000, 32'hFFFF_FFFF);
    send_request(KIND_STORE_CONST,  16'h0000, 32'h0000_0000);
    send_request(KIND_FETCH_GLOBAL, 16'h0000, 32'h0000_0000);
    send_request(KIND_FETCH_CONST,  16'h0000, 32'hFFFF_FFFF);
    send_request(KIND_STORE_GLOBAL, 16'hFFFF, 32'hA5A5_5A5A);
    send_request(KIND_STORE_GLOBAL, 16'hFFFF, 32'h5A5A_A5A5);
    send_request(KIND_FETCH_GLOBAL, 16'hFFFF, 32'h0000_0000);
    send_request(KIND_FETCH_CONST,  16'hFFFF, 32'h0000_0000);
    send_request(KIND_STORE_CONST,  16'hFFFF, 32'h8000_0001);
    send_request(KIND_FETCH_CONST,  16'hFFFF, 32'hDEAD_BEEF);
    send_request(KIND_STORE_CONST,  16'h0000, 32'hFFFF_FFFF);
    send_request(KIND_FETCH_CONST,  16'h0000, 32'h0000_0000);
    send_request(KIND_FETCH_GLOBAL, 16'h8001, 32'h0000_0000);

    // Random: mostly pool keys so stores and fetches hit; the mix overfills the table.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      idle_on = !(n >= 700 && n < 1000);
      k = kind_t'($urandom_range(3));
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL - 1)];
      else key = KEY_BITS'($urandom_range(16'hFFFF));
      send_request(k, key, $urandom);
    end
    in_valid <= 1'b0;
    idle_on = 1'b1;

    // Drain, then allow stray results time to show up.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3 * DEPTH) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[global_symbol_value_table.f]
hw/rtl/gsvt_pkg.sv
hw/rtl/gsvt_cell.sv
hw/rtl/global_symbol_value_table.sv
dv/tb_top.sv
